/* design/alc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alc_pkg
// Shared widths, register indexes, coefficient tables and the config struct
// for the ambient light lux calculator.
// ----------------------------------------------------------------------------
package alc_pkg;

	// field and internal widths
	localparam int CNT_W   = 16;            // raw channel count
	localparam int SCF_W   = 19;            // scale factor incl. gain shift
	localparam int SFRAC_W = 10;            // scale factor fraction bits
	localparam int SC_W    = 25;            // scaled channel count
	localparam int RFRAC_W = 9;             // ratio fraction bits
	localparam int NUM_W   = SC_W + RFRAC_W + 1;  // ir << 10
	localparam int THR_W   = 11;            // 2*breakpoint+1
	localparam int TP_W    = SC_W + THR_W;  // threshold product
	localparam int COEF_W  = 10;            // offset / slope
	localparam int MAC_W   = SC_W + COEF_W; // product width
	localparam int LFRAC_W = 14;            // lux fraction bits
	localparam int LUX_W   = 21;
	localparam int SEG_N   = 8;
	localparam int SEG_W   = 3;
	localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(SEG_N - 1);
	localparam logic [LUX_W-1:0] LUX_MAX  = 21'd1205297;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_HIGH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PACKAGE_CS = 2'd2;

	// integration modes
	localparam logic [1:0] INTEG_SHORT  = 2'd0;
	localparam logic [1:0] INTEG_MEDIUM = 2'd1;
	localparam logic [1:0] INTEG_LONG   = 2'd2;

	localparam logic [SCF_W-1:0] SCALE_SHORT  = 19'h07517;
	localparam logic [SCF_W-1:0] SCALE_MEDIUM = 19'h00fe7;
	localparam logic [SCF_W-1:0] SCALE_UNITY  = 19'h00400;
	localparam int               GAIN_SHIFT   = 4;

	typedef logic [SC_W-1:0]   scaled_t;
	typedef logic [SEG_W-1:0]  seg_t;
	typedef logic [COEF_W-1:0] coef_t;

	typedef struct packed {
		logic       gain_high;
		logic [1:0] integration_mode;
		logic       package_cs;
	} cfg_t;

	typedef logic [9:0] tab_row_t [SEG_N];

	localparam tab_row_t BRK_T = '{10'h040, 10'h080, 10'h0c0, 10'h100,
	                                10'h138, 10'h19a, 10'h29a, 10'h29a};
	localparam tab_row_t BRK_C = '{10'h043, 10'h085, 10'h0c8, 10'h10a,
	                                10'h14d, 10'h19a, 10'h29a, 10'h29a};
	localparam tab_row_t OFS_T = '{10'h1f2, 10'h214, 10'h23f, 10'h270,
	                                10'h16f, 10'h0d2, 10'h018, 10'h000};
	localparam tab_row_t OFS_C = '{10'h204, 10'h228, 10'h253, 10'h282,
	                                10'h177, 10'h101, 10'h037, 10'h000};
	localparam tab_row_t SLP_T = '{10'h1be, 10'h2d1, 10'h37b, 10'h3fe,
	                                10'h1fc, 10'h0fb, 10'h012, 10'h000};
	localparam tab_row_t SLP_C = '{10'h1ad, 10'h2c1, 10'h363, 10'h3df,
	                                10'h1dd, 10'h127, 10'h02b, 10'h000};

	// r <= B  is the same as  q <= 2B  is the same as  num < (2B+1)*sbb
	function automatic logic [THR_W-1:0] brk_thr(input logic cs, input seg_t idx);
		logic [9:0] b;
		b = cs ? BRK_C[idx] : BRK_T[idx];
		return {b, 1'b1};
	endfunction

	function automatic coef_t ofs_coef(input logic cs, input seg_t idx);
		return cs ? OFS_C[idx] : OFS_T[idx];
	endfunction

	function automatic coef_t slp_coef(input logic cs, input seg_t idx);
		return cs ? SLP_C[idx] : SLP_T[idx];
	endfunction

endpackage

/* design/ambient_light_lux_calc_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ambient_light_lux_calc_top
// Integer lux from a broadband / infrared count pair, five-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: broadband_count and infrared_count, taken when in_valid is
//   high and in_stall is low. Output beat: lux_value, taken when out_valid
//   is high and out_stall is low. Exactly one output beat per input beat,
//   in order.
//   An accepted input beat passes five register stages, stage 1 to stage 5,
//   before it shows on out_valid. One beat per cycle is sustained while
//   out_stall is low: scale multiply, threshold multiply, segment compare,
//   coefficient multiply and round/shift each own a stage.
//   While the output beat waits on out_stall, the whole pipeline holds and
//   in_stall is raised in the same cycle; nothing is dropped or repeated.
//   Reset (arst_n low) empties the pipeline and loads gain_high = 0,
//   integration_mode = 2 and package_cs = 1. Write the registers through
//   cfg_we / cfg_index / cfg_data only while the pipeline is empty; the
//   block does not enforce it. An index beyond the list is ignored.
// ----------------------------------------------------------------------------
module ambient_light_lux_calc_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [alc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [alc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [alc_pkg::CNT_W-1:0]          broadband_count,
	input  logic [alc_pkg::CNT_W-1:0]          infrared_count,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [alc_pkg::LUX_W-1:0]          lux_value
);

	alc_pkg::cfg_t    cfg_q;
	logic             adv;
	logic             v_s1;
	logic             v_s3;
	alc_pkg::scaled_t sbb_s1;
	alc_pkg::scaled_t sir_s1;
	alc_pkg::scaled_t sbb_s3;
	alc_pkg::scaled_t sir_s3;
	alc_pkg::seg_t    seg_s3;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_high        <= 1'b0;
			cfg_q.integration_mode <= alc_pkg::INTEG_LONG;
			cfg_q.package_cs       <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				alc_pkg::REG_GAIN_HIGH:  cfg_q.gain_high        <= cfg_data[0];
				alc_pkg::REG_INTEG_MODE: cfg_q.integration_mode <= cfg_data[1:0];
				alc_pkg::REG_PACKAGE_CS: cfg_q.package_cs       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// pipeline advances unless the output beat is held
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	alc_scale u_scale (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.cfg             (cfg_q),
		.in_valid        (in_valid),
		.broadband_count (broadband_count),
		.infrared_count  (infrared_count),
		.v_s1            (v_s1),
		.sbb_s1          (sbb_s1),
		.sir_s1          (sir_s1)
	);

	alc_seg u_seg (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cfg    (cfg_q),
		.v_s1   (v_s1),
		.sbb_s1 (sbb_s1),
		.sir_s1 (sir_s1),
		.v_s3   (v_s3),
		.seg_s3 (seg_s3),
		.sbb_s3 (sbb_s3),
		.sir_s3 (sir_s3)
	);

	alc_lux u_lux (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cfg    (cfg_q),
		.v_s3   (v_s3),
		.seg_s3 (seg_s3),
		.sbb_s3 (sbb_s3),
		.sir_s3 (sir_s3),
		.v_s5   (out_valid),
		.lux_s5 (lux_value)
	);

`ifndef SYNTH
	// a held output beat must hold the input side too
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> in_stall)
		else $error("input accepted while output beat is held");

	// result never exceeds the largest reachable lux value
	a_lux_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (lux_value <= alc_pkg::LUX_MAX))
		else $error("lux value out of range");

	// with no stall an accepted beat leaves stage 1 valid
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted beat lost at pipeline entry");
`endif

endmodule

/* design/alc_scale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alc_scale
// Stage 1: scales both channel counts for integration time and gain.
// ----------------------------------------------------------------------------
module alc_scale (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  alc_pkg::cfg_t                 cfg,
	input  logic                          in_valid,
	input  logic [alc_pkg::CNT_W-1:0]     broadband_count,
	input  logic [alc_pkg::CNT_W-1:0]     infrared_count,
	output logic                          v_s1,
	output alc_pkg::scaled_t              sbb_s1,
	output alc_pkg::scaled_t              sir_s1
);

	localparam int PW = alc_pkg::CNT_W + alc_pkg::SCF_W;

	logic [alc_pkg::SCF_W-1:0] base_f;
	logic [alc_pkg::SCF_W-1:0] f;
	logic [PW-1:0]             bb_p;
	logic [PW-1:0]             ir_p;

	// scale factor from integration mode, times 16 at low gain
	always_comb begin
		case (cfg.integration_mode)
			alc_pkg::INTEG_SHORT:  base_f = alc_pkg::SCALE_SHORT;
			alc_pkg::INTEG_MEDIUM: base_f = alc_pkg::SCALE_MEDIUM;
			default:               base_f = alc_pkg::SCALE_UNITY;
		endcase
		f = cfg.gain_high ? base_f : (base_f << alc_pkg::GAIN_SHIFT);
	end

	assign bb_p = PW'(broadband_count) * PW'(f);
	assign ir_p = PW'(infrared_count) * PW'(f);

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	// stage 1 data
	always_ff @(posedge clk) begin
		if (adv) begin
			sbb_s1 <= bb_p[PW-1:alc_pkg::SFRAC_W];
			sir_s1 <= ir_p[PW-1:alc_pkg::SFRAC_W];
		end
	end

endmodule

/* design/alc_seg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alc_seg
// Stages 2 and 3: picks the coefficient segment from the rounded IR ratio by
// comparing ir<<10 against (2*breakpoint+1)*broadband for every breakpoint.
// ----------------------------------------------------------------------------
module alc_seg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  alc_pkg::cfg_t     cfg,
	input  logic              v_s1,
	input  alc_pkg::scaled_t  sbb_s1,
	input  alc_pkg::scaled_t  sir_s1,
	output logic              v_s3,
	output alc_pkg::seg_t     seg_s3,
	output alc_pkg::scaled_t  sbb_s3,
	output alc_pkg::scaled_t  sir_s3
);

	localparam int NB = alc_pkg::SEG_N - 1;

	logic [alc_pkg::TP_W-1:0]  tp   [NB];
	logic [alc_pkg::TP_W-1:0]  tp_s2 [NB];
	logic                      v_s2;
	logic                      zero_s2;
	alc_pkg::scaled_t          sbb_s2;
	alc_pkg::scaled_t          sir_s2;
	alc_pkg::seg_t             seg_d;

	// threshold products
	always_comb begin
		for (int i = 0; i < NB; i++) begin
			tp[i] = alc_pkg::TP_W'(sbb_s1) *
			        alc_pkg::TP_W'(alc_pkg::brk_thr(cfg.package_cs,
			                                       alc_pkg::SEG_W'(i)));
		end
	end

	// first breakpoint the ratio stays under; zero broadband uses segment 0
	always_comb begin
		logic [alc_pkg::TP_W-1:0] num;
		num   = alc_pkg::TP_W'({sir_s2, {(alc_pkg::RFRAC_W + 1){1'b0}}});
		seg_d = alc_pkg::SEG_LAST;
		for (int i = NB - 1; i >= 0; i--) begin
			if (num < tp_s2[i]) seg_d = alc_pkg::SEG_W'(i);
		end
		if (zero_s2) seg_d = '0;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 2 and 3 data
	always_ff @(posedge clk) begin
		if (adv) begin
			tp_s2   <= tp;
			zero_s2 <= (sbb_s1 == '0);
			sbb_s2  <= sbb_s1;
			sir_s2  <= sir_s1;
			seg_s3  <= seg_d;
			sbb_s3  <= sbb_s2;
			sir_s3  <= sir_s2;
		end
	end

`ifndef SYNTH
	// zero broadband always lands in the first segment
	a_zero_seg: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && zero_s2 && adv) |=> (seg_s3 == '0))
		else $error("zero broadband did not select segment 0");
`endif

endmodule

/* design/alc_lux.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alc_lux
// Stages 4 and 5: offset*broadband and slope*infrared, clamped difference,
// rounding and the final shift to whole lux.
// ----------------------------------------------------------------------------
module alc_lux (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  alc_pkg::cfg_t             cfg,
	input  logic                      v_s3,
	input  alc_pkg::seg_t             seg_s3,
	input  alc_pkg::scaled_t          sbb_s3,
	input  alc_pkg::scaled_t          sir_s3,
	output logic                      v_s5,
	output logic [alc_pkg::LUX_W-1:0] lux_s5
);

	localparam int MW = alc_pkg::MAC_W;

	logic            v_s4;
	logic [MW-1:0]   pos_s4;
	logic [MW-1:0]   neg_s4;
	logic [MW-1:0]   diff;
	logic [MW:0]     rnd;
	alc_pkg::coef_t  ofs;
	alc_pkg::coef_t  slp;

	assign ofs = alc_pkg::ofs_coef(cfg.package_cs, seg_s3);
	assign slp = alc_pkg::slp_coef(cfg.package_cs, seg_s3);

	// clamp, add half an lsb, drop the fraction
	always_comb begin
		diff = (pos_s4 > neg_s4) ? (pos_s4 - neg_s4) : '0;
		rnd  = {1'b0, diff} + ((MW + 1)'(1) << (alc_pkg::LFRAC_W - 1));
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 4 and 5 data
	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s4 <= MW'(sbb_s3) * MW'(ofs);
			neg_s4 <= MW'(sir_s3) * MW'(slp);
			lux_s5 <= rnd[alc_pkg::LFRAC_W +: alc_pkg::LUX_W];
		end
	end

`ifndef SYNTH
	// the segment past the last breakpoint has zero coefficients
	a_last_seg: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && seg_s3 == alc_pkg::SEG_LAST && adv) |=>
		(pos_s4 == '0 && neg_s4 == '0))
		else $error("last segment produced a nonzero product");
`endif

endmodule
